[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check under reset release, clocked on clk.
`define GQL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define GQL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GQL_ASSERT(lbl, prop, msg)
`define GQL_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[rtl/gql_pkg.sv]
// ----------------------------------------------------------------------------
// gql_pkg
// Types and constants shared by the glyph quad layout block.
// ----------------------------------------------------------------------------
package gql_pkg;

	localparam int POS_W      = 20;
	localparam int CODE_W     = 8;
	localparam int OFS_W      = 16;
	localparam int EXT_W      = 12;
	localparam int SCALE_W    = 12;
	localparam int LH_W       = 16;
	localparam int COLOR_W    = 32;
	localparam int TC_W       = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int SCALE_FRAC = 8;
	localparam int PIX_FRAC   = 4;
	// signed and unsigned product widths, scaled signed and unsigned widths, vertex sum width
	localparam int SP_W   = OFS_W + SCALE_W + 1;
	localparam int UP_W   = OFS_W + SCALE_W;
	localparam int SCL_W  = SP_W - SCALE_FRAC;
	localparam int USCL_W = UP_W - SCALE_FRAC;
	localparam int SUM_W  = 24;

	localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_LAYOUT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_START_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR       = 3'd4;

	localparam int VTX_CNT_W = 3;
	localparam logic [VTX_CNT_W-1:0] VTX_V0   = 3'd0;
	localparam logic [VTX_CNT_W-1:0] VTX_V1   = 3'd1;
	localparam logic [VTX_CNT_W-1:0] VTX_V2   = 3'd2;
	localparam logic [VTX_CNT_W-1:0] VTX_V0B  = 3'd3;
	localparam logic [VTX_CNT_W-1:0] VTX_V2B  = 3'd4;
	localparam logic [VTX_CNT_W-1:0] VTX_LAST = 3'd5;

	typedef struct packed {
		logic                     func;
		logic [CODE_W-1:0]        char_code;
		logic                     first_char;
		logic signed [OFS_W-1:0]  load_x_offset;
		logic signed [OFS_W-1:0]  load_y_offset;
		logic [EXT_W-1:0]         load_width;
		logic [EXT_W-1:0]         load_height;
		logic signed [OFS_W-1:0]  load_advance;
		logic [TC_W-1:0]          load_u_left;
		logic [TC_W-1:0]          load_u_right;
		logic [TC_W-1:0]          load_v_bottom;
		logic [TC_W-1:0]          load_v_top;
	} req_t;

	typedef struct packed {
		logic signed [POS_W-1:0] vertex_x;
		logic signed [POS_W-1:0] vertex_y;
		logic [TC_W-1:0]         tex_u;
		logic [TC_W-1:0]         tex_v;
		logic [COLOR_W-1:0]      vertex_color;
		logic                    last_vertex;
	} vtx_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
	} cfg_t;

	typedef struct packed {
		logic signed [OFS_W-1:0] ofs_x;
		logic signed [OFS_W-1:0] ofs_y;
		logic [EXT_W-1:0]        width;
		logic [EXT_W-1:0]        height;
		logic signed [OFS_W-1:0] advance;
		logic [TC_W-1:0]         u_left;
		logic [TC_W-1:0]         u_right;
		logic [TC_W-1:0]         v_bottom;
		logic [TC_W-1:0]         v_top;
	} glyph_t;

	typedef struct packed {
		logic hit;
		logic newline;
		logic first_char;
	} ctl_t;

	typedef struct packed {
		ctl_t                    ctl;
		logic signed [SCL_W-1:0] sxo;
		logic signed [SCL_W-1:0] syo;
		logic signed [SCL_W-1:0] sadv;
		logic [USCL_W-1:0]       w;
		logic [USCL_W-1:0]       h;
		logic [USCL_W-1:0]       lh;
		logic [TC_W-1:0]         u_left;
		logic [TC_W-1:0]         u_right;
		logic [TC_W-1:0]         v_bottom;
		logic [TC_W-1:0]         v_top;
	} scaled_t;

endpackage

[rtl/gql_chan_if.sv]
// ----------------------------------------------------------------------------
// gql_chan_if
// Valid/ready channel carrying one payload of type T per request.
// ----------------------------------------------------------------------------
interface gql_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/gql_table.sv]
// ----------------------------------------------------------------------------
// gql_table
// Glyph metrics memory with presence bits; decodes requests into stage 1.
// ----------------------------------------------------------------------------
module gql_table #(
	parameter int GLYPH_FIRST = 32,
	parameter int GLYPH_COUNT = 96
) (
	input  logic            clk,
	input  logic            arst_n,
	gql_chan_if.sink        req,
	output logic            s1_valid,
	output gql_pkg::ctl_t   s1_ctl,
	output gql_pkg::glyph_t s1_glyph,
	input  logic            s1_ready
);

	localparam int IDX_W  = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
	localparam int DIFF_W = gql_pkg::CODE_W + 2;

	gql_pkg::glyph_t          mem [GLYPH_COUNT];
	logic [GLYPH_COUNT-1:0]   present_q;
	logic [DIFF_W-1:0]        diff;
	logic                     in_table;
	logic [IDX_W-1:0]         idx;
	logic                     accept;
	logic                     is_layout;
	logic                     wr_en;
	gql_pkg::glyph_t          wr_entry;
	gql_pkg::ctl_t            ctl;
	logic                     s1_valid_q;
	gql_pkg::ctl_t            ctl_s1;
	gql_pkg::glyph_t          glyph_s1;

	assign diff      = DIFF_W'(req.data.char_code) - DIFF_W'(GLYPH_FIRST);
	assign in_table  = !diff[DIFF_W-1] && (diff < DIFF_W'(GLYPH_COUNT));
	assign idx       = diff[IDX_W-1:0];
	assign accept    = req.valid && req.ready;
	assign is_layout = (req.data.func == gql_pkg::FUNC_LAYOUT);
	assign wr_en     = accept && !is_layout && in_table;
	assign req.ready = !s1_valid_q || s1_ready;

	always_comb begin
		wr_entry.ofs_x    = req.data.load_x_offset;
		wr_entry.ofs_y    = req.data.load_y_offset;
		wr_entry.width    = req.data.load_width;
		wr_entry.height   = req.data.load_height;
		wr_entry.advance  = req.data.load_advance;
		wr_entry.u_left   = req.data.load_u_left;
		wr_entry.u_right  = req.data.load_u_right;
		wr_entry.v_bottom = req.data.load_v_bottom;
		wr_entry.v_top    = req.data.load_v_top;

		ctl.newline    = (req.data.char_code == gql_pkg::NEWLINE_CODE);
		ctl.first_char = req.data.first_char;
		ctl.hit        = !ctl.newline && in_table && present_q[idx];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_layout && in_table) begin
			glyph_s1 <= mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q  <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				present_q[idx] <= 1'b1;
			end
			if (req.ready) begin
				s1_valid_q <= accept && is_layout;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl;
		end
	end

	assign s1_valid = s1_valid_q;
	assign s1_ctl   = ctl_s1;
	assign s1_glyph = glyph_s1;

endmodule

[rtl/gql_scale.sv]
// ----------------------------------------------------------------------------
// gql_scale
// Scales glyph metrics and line height by the configured factor, rounded.
// ----------------------------------------------------------------------------
module gql_scale (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s1_valid,
	input  gql_pkg::ctl_t                      s1_ctl,
	input  gql_pkg::glyph_t                    s1_glyph,
	output logic                               s1_ready,
	input  logic [gql_pkg::SCALE_W-1:0]        scale,
	input  logic [gql_pkg::LH_W-1:0]           line_height,
	output logic                               s2_valid,
	output gql_pkg::scaled_t                   s2_data,
	input  logic                               s2_ready
);

	localparam int SP_W   = gql_pkg::SP_W;
	localparam int UP_W   = gql_pkg::UP_W;
	localparam int FRAC   = gql_pkg::SCALE_FRAC;
	localparam int ROUND  = 1 << (FRAC - 1);

	function automatic logic signed [gql_pkg::SCL_W-1:0] round_s(
		input logic signed [gql_pkg::OFS_W-1:0]   q,
		input logic signed [gql_pkg::SCALE_W:0]   s
	);
		logic signed [SP_W-1:0] p;
		p = SP_W'(q) * SP_W'(s) + SP_W'(ROUND);
		return p[SP_W-1:FRAC];
	endfunction

	function automatic logic [gql_pkg::USCL_W-1:0] round_u(
		input logic [gql_pkg::OFS_W-1:0]   q,
		input logic [gql_pkg::SCALE_W-1:0] s
	);
		logic [UP_W-1:0] p;
		p = UP_W'(q) * UP_W'(s) + UP_W'(ROUND);
		return p[UP_W-1:FRAC];
	endfunction

	logic signed [gql_pkg::SCALE_W:0] scl_s;
	gql_pkg::scaled_t                 nxt;
	logic                             s2_valid_q;
	gql_pkg::scaled_t                 data_s2;

	assign scl_s    = signed'({1'b0, scale});
	assign s1_ready = !s2_valid_q || s2_ready;

	always_comb begin
		nxt.ctl      = s1_ctl;
		nxt.sxo      = round_s(s1_glyph.ofs_x, scl_s);
		nxt.syo      = round_s(s1_glyph.ofs_y, scl_s);
		nxt.sadv     = round_s(s1_glyph.advance, scl_s);
		nxt.w        = round_u({s1_glyph.width, {gql_pkg::PIX_FRAC{1'b0}}}, scale);
		nxt.h        = round_u({s1_glyph.height, {gql_pkg::PIX_FRAC{1'b0}}}, scale);
		nxt.lh       = round_u(line_height, scale);
		nxt.u_left   = s1_glyph.u_left;
		nxt.u_right  = s1_glyph.u_right;
		nxt.v_bottom = s1_glyph.v_bottom;
		nxt.v_top    = s1_glyph.v_top;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s1_ready) begin
			s2_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid && s1_ready) begin
			data_s2 <= nxt;
		end
	end

	assign s2_valid = s2_valid_q;
	assign s2_data  = data_s2;

endmodule

[rtl/gql_quad.sv]
// ----------------------------------------------------------------------------
// gql_quad
// Pen update and six-vertex quad emitter feeding the vertex channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gql_quad (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s2_valid,
	input  gql_pkg::scaled_t                  s2_data,
	output logic                              s2_ready,
	input  logic signed [gql_pkg::POS_W-1:0]  start_x,
	input  logic signed [gql_pkg::POS_W-1:0]  start_y,
	input  logic [gql_pkg::COLOR_W-1:0]       color_rgba,
	gql_chan_if.source                        vtx
);

	localparam int POS_W = gql_pkg::POS_W;
	localparam int SUM_W = gql_pkg::SUM_W;
	localparam int TC_W  = gql_pkg::TC_W;

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
		logic fits;
		fits = (v[SUM_W-1:POS_W-1] == '0) || (v[SUM_W-1:POS_W-1] == '1);
		if (fits) begin
			return v[POS_W-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			return {1'b0, {(POS_W-1){1'b1}}};
		end
	endfunction

	logic signed [POS_W-1:0]  pen_x_q, pen_y_q;
	logic signed [POS_W-1:0]  pen_bx, pen_by;
	logic signed [POS_W-1:0]  pen_x_n, pen_y_n;
	logic signed [SUM_W-1:0]  x0, y0, x1, y1;
	logic signed [POS_W-1:0]  x0_q, y0_q, x1_q, y1_q;
	logic [TC_W-1:0]          ul_q, ur_q, vb_q, vt_q;
	logic [gql_pkg::VTX_CNT_W-1:0] cnt_q;
	logic                     busy_q;
	logic                     fire, last_fire, can_load, step, load;
	gql_pkg::vtx_t            vout;

	assign fire      = vtx.valid && vtx.ready;
	assign last_fire = fire && (cnt_q == gql_pkg::VTX_LAST);
	assign can_load  = !busy_q || last_fire;
	assign s2_ready  = !s2_data.ctl.hit || can_load;
	assign step      = s2_valid && s2_ready;
	assign load      = step && s2_data.ctl.hit;

	always_comb begin
		pen_bx = s2_data.ctl.first_char ? start_x : pen_x_q;
		pen_by = s2_data.ctl.first_char ? start_y : pen_y_q;
		x0 = SUM_W'(pen_bx) + SUM_W'(s2_data.sxo);
		y0 = SUM_W'(pen_by) + SUM_W'(s2_data.syo);
		x1 = x0 + signed'(SUM_W'(s2_data.w));
		y1 = y0 + signed'(SUM_W'(s2_data.h));
		pen_x_n = pen_bx;
		pen_y_n = pen_by;
		if (s2_data.ctl.newline) begin
			pen_x_n = start_x;
			pen_y_n = sat_pos(SUM_W'(pen_by) + signed'(SUM_W'(s2_data.lh)));
		end else if (s2_data.ctl.hit) begin
			pen_x_n = sat_pos(SUM_W'(pen_bx) + SUM_W'(s2_data.sadv));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= '0;
			pen_y_q <= '0;
			busy_q  <= 1'b0;
			cnt_q   <= gql_pkg::VTX_V0;
		end else begin
			if (step) begin
				pen_x_q <= pen_x_n;
				pen_y_q <= pen_y_n;
			end
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= gql_pkg::VTX_V0;
			end else if (last_fire) begin
				busy_q <= 1'b0;
			end else if (fire) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x0_q <= sat_pos(x0);
			y0_q <= sat_pos(y0);
			x1_q <= sat_pos(x1);
			y1_q <= sat_pos(y1);
			ul_q <= s2_data.u_left;
			ur_q <= s2_data.u_right;
			vb_q <= s2_data.v_bottom;
			vt_q <= s2_data.v_top;
		end
	end

	always_comb begin
		vout.vertex_color = color_rgba;
		vout.last_vertex  = 1'b0;
		case (cnt_q)
			gql_pkg::VTX_V1: begin
				vout.vertex_x = x1_q;
				vout.vertex_y = y0_q;
				vout.tex_u    = ur_q;
				vout.tex_v    = vt_q;
			end
			gql_pkg::VTX_V2, gql_pkg::VTX_V2B: begin
				vout.vertex_x = x1_q;
				vout.vertex_y = y1_q;
				vout.tex_u    = ur_q;
				vout.tex_v    = vb_q;
			end
			gql_pkg::VTX_LAST: begin
				vout.vertex_x    = x0_q;
				vout.vertex_y    = y1_q;
				vout.tex_u       = ul_q;
				vout.tex_v       = vb_q;
				vout.last_vertex = 1'b1;
			end
			default: begin
				vout.vertex_x = x0_q;
				vout.vertex_y = y0_q;
				vout.tex_u    = ul_q;
				vout.tex_v    = vt_q;
			end
		endcase
	end

	assign vtx.valid = busy_q;
	assign vtx.data  = vout;

	`GQL_ASSERT(a_cnt_range, cnt_q <= gql_pkg::VTX_LAST, "vertex counter out of range")
	`GQL_ASSERT(a_load_start, load |=> (busy_q && cnt_q == gql_pkg::VTX_V0), "quad load lost")
	`GQL_ASSERT(a_drain, (last_fire && !load) |=> !busy_q, "emitter did not drain")
	`GQL_ASSERT(a_pen_hold, !step |=> ($stable(pen_x_q) && $stable(pen_y_q)), "pen moved idle")

endmodule

[rtl/glyph_quad_layout.sv]
// ----------------------------------------------------------------------------
// glyph_quad_layout
// Bitmap font glyph quad generator: glyph table load and character layout.
// ----------------------------------------------------------------------------
//  channel  role    payload  request
//  req      sink    req_t    glyph load or one character to lay out
//  vtx      source  vtx_t    one vertex of a glyph quad
//  cfg      sink    cfg_t    register write, index and value
//
//  A known glyph yields six vertices on vtx; loads, newlines and unknown
//  codes yield none. The first vertex follows the table and scale registers.
//  The six-vertex emitter sets the rate; pen and table read stay in order.
//  Reset clears presence bits at once; glyph memory is undefined until loaded.
//  vtx.ready low holds the emitter; a waiting known glyph backs up to req.
// ----------------------------------------------------------------------------
module glyph_quad_layout #(
	parameter int GLYPH_FIRST = 32,
	parameter int GLYPH_COUNT = 96
) (
	input logic        clk,
	input logic        arst_n,
	gql_chan_if.sink   req,
	gql_chan_if.source vtx,
	gql_chan_if.sink   cfg
);

	logic signed [gql_pkg::POS_W-1:0] start_x_q, start_y_q;
	logic [gql_pkg::SCALE_W-1:0]      scale_q;
	logic [gql_pkg::LH_W-1:0]         line_height_q;
	logic [gql_pkg::COLOR_W-1:0]      color_q;

	logic             s1_valid, s1_ready;
	gql_pkg::ctl_t    s1_ctl;
	gql_pkg::glyph_t  s1_glyph;
	logic             s2_valid, s2_ready;
	gql_pkg::scaled_t s2_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q     <= '0;
			start_y_q     <= '0;
			scale_q       <= gql_pkg::SCALE_W'(256);
			line_height_q <= '0;
			color_q       <= '1;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.data.index)
				gql_pkg::CFG_START_X: begin
					start_x_q <= signed'(cfg.data.value[gql_pkg::POS_W-1:0]);
				end
				gql_pkg::CFG_START_Y: begin
					start_y_q <= signed'(cfg.data.value[gql_pkg::POS_W-1:0]);
				end
				gql_pkg::CFG_SCALE: begin
					scale_q <= cfg.data.value[gql_pkg::SCALE_W-1:0];
				end
				gql_pkg::CFG_LINE_HEIGHT: begin
					line_height_q <= cfg.data.value[gql_pkg::LH_W-1:0];
				end
				gql_pkg::CFG_COLOR: begin
					color_q <= cfg.data.value[gql_pkg::COLOR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	gql_table #(
		.GLYPH_FIRST(GLYPH_FIRST),
		.GLYPH_COUNT(GLYPH_COUNT)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.s1_valid (s1_valid),
		.s1_ctl   (s1_ctl),
		.s1_glyph (s1_glyph),
		.s1_ready (s1_ready)
	);

	gql_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.s1_valid    (s1_valid),
		.s1_ctl      (s1_ctl),
		.s1_glyph    (s1_glyph),
		.s1_ready    (s1_ready),
		.scale       (scale_q),
		.line_height (line_height_q),
		.s2_valid    (s2_valid),
		.s2_data     (s2_data),
		.s2_ready    (s2_ready)
	);

	gql_quad u_quad (
		.clk        (clk),
		.arst_n     (arst_n),
		.s2_valid   (s2_valid),
		.s2_data    (s2_data),
		.s2_ready   (s2_ready),
		.start_x    (start_x_q),
		.start_y    (start_y_q),
		.color_rgba (color_q),
		.vtx        (vtx)
	);

endmodule
